FILE: rtl/coherent_set_assoc_cache_assert.svh
// Assertion macros for the coherent cache block
`ifndef COHERENT_SET_ASSOC_CACHE_ASSERT_SVH
`define COHERENT_SET_ASSOC_CACHE_ASSERT_SVH
// implication checked each clock, off during reset
`define CSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/csac_pkg.sv
// Shared types and codes of the coherent cache block
`default_nettype none
package csac_pkg;
    localparam logic [2:0] ST_I = 3'd0;
    localparam logic [2:0] ST_S = 3'd1;
    localparam logic [2:0] ST_E = 3'd2;
    localparam logic [2:0] ST_O = 3'd3;
    localparam logic [2:0] ST_M = 3'd4;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_RD   = 2'd1;
    localparam logic [1:0] CMD_RDX  = 2'd2;
    localparam logic [1:0] CMD_UPGR = 2'd3;

    localparam logic [2:0] REQ_RD   = 3'd0;
    localparam logic [2:0] REQ_WR   = 3'd1;
    localparam logic [2:0] REQ_BRD  = 3'd2;
    localparam logic [2:0] REQ_BRDX = 3'd3;
    localparam logic [2:0] REQ_BUPG = 3'd4;

    localparam logic [1:0] MODE_WB   = 2'd0;
    localparam logic [1:0] MODE_MSI  = 2'd1;
    localparam logic [1:0] MODE_MESI = 2'd2;
    localparam logic [1:0] MODE_MOESI = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture input item
        logic update;  // write back set, load result
        logic clear;   // clear one row
    } t_csac_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
    } t_csac_status;
endpackage
`default_nettype wire

FILE: rtl/csac_ctrl.sv
// Controller state machine of the coherent cache block
`default_nettype none
module csac_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    input  wire csac_pkg::t_csac_status i_status,
    output csac_pkg::t_csac_cmd        o_cmd
);
    import csac_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LOOK  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    logic in_xfer, out_xfer;
    // accept while a result waits only if it leaves this cycle
    assign o_ready  = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = r_out_valid && i_ready;
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (out_xfer) n_out_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.load = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.update = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `include "coherent_set_assoc_cache_assert.svh"
    `CSC_ASSERT_IMP(a_no_accept_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_ready)
    `CSC_ASSERT_NEXT(a_load_look, i_clk, i_rst_n, o_cmd.load, r_state == S_LOOK)
    `CSC_ASSERT_NEXT(a_update_valid, i_clk, i_rst_n, o_cmd.update, o_valid)
endmodule
`default_nettype wire

FILE: rtl/csac_dp.sv
// Datapath of the coherent cache block: set memories, lookup and update
`default_nettype none
module csac_dp #(
    parameter int SETS       = 256,
    parameter int WAYS       = 8,
    parameter int LINE_BYTES = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire csac_pkg::t_csac_cmd    i_cmd,
    output csac_pkg::t_csac_status      o_status,
    input  wire logic [1:0]             i_mode,
    input  wire logic [2:0]             i_req_type,
    input  wire logic [31:0]            i_address,
    input  wire logic                   i_shared_elsewhere,
    input  wire logic                   i_dirty_elsewhere,
    output logic                        o_hit,
    output logic [1:0]                  o_bus_command,
    output logic                        o_write_back,
    output logic [25:0]                 o_victim_line_address,
    output logic                        o_flush,
    output logic                        o_invalidation,
    output logic                        o_intervention,
    output logic                        o_cache_to_cache,
    output logic [2:0]                  o_old_state,
    output logic [2:0]                  o_new_state
);
    import csac_pkg::*;

    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SET_B = $clog2(SETS);
    localparam int TAG_W = 32 - OFF_W - SET_B;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RNK_W = WAY_W;

    typedef logic [WAYS-1:0][TAG_W-1:0] t_tags;
    typedef logic [WAYS-1:0][2:0]       t_sts;
    typedef logic [WAYS-1:0][RNK_W-1:0] t_rnks;

    // one row per set, all ways side by side
    t_tags r_tag_mem [SETS];
    t_sts  r_st_mem  [SETS];
    t_rnks r_rk_mem  [SETS];
    t_tags r_tags;
    t_sts  r_sts;
    t_rnks r_rnks;

    logic [2:0]       r_req;
    logic [TAG_W-1:0] r_tag;
    logic [SET_W-1:0] r_set;
    logic             r_sh, r_dy;
    logic [SET_W-1:0] r_clr;

    logic [SET_W-1:0] a_set;
    logic [31:0]      a_line;
    assign a_line = i_address >> OFF_W;
    assign a_set  = (SETS > 1) ? SET_W'(a_line[SET_W-1:0]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + SET_W'(1);
        end
    end
    assign o_status.clear_done = (r_clr == SET_W'(SETS - 1));

    // lookup and new row
    logic             hit, hit_out, wr, proc, miss_fill;
    logic [WAY_W-1:0] hway, vway, way;
    logic [2:0]       olds, news;
    logic [1:0]       cmd;
    logic             wb, fl, inv, itv, c2c, have_inv, wr_row;
    logic [25:0]      vaddr;
    t_sts             n_sts;
    t_rnks            n_rnks;
    t_tags            n_tags;
    logic [RNK_W-1:0] trk;
    logic [31:0]      vline;

    always_comb begin
        hit = 1'b0; hway = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_sts[w] != ST_I && r_tags[w] == r_tag) begin
                hit = 1'b1; hway = WAY_W'(w);
            end
        end
        have_inv = 1'b0; vway = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_sts[w] == ST_I) begin
                have_inv = 1'b1; vway = WAY_W'(w);
            end
        end
        if (!have_inv) begin
            // last way with the lowest rank
            for (int w = 0; w < WAYS; w++) begin
                if (r_rnks[w] <= r_rnks[vway]) vway = WAY_W'(w);
            end
        end
    end

    always_comb begin
        proc = (r_req == REQ_RD) || (r_req == REQ_WR);
        wr   = (r_req == REQ_WR);
        hit_out = hit;
        olds = hit ? r_sts[hway] : ST_I;
        news = olds;
        cmd = CMD_NONE; wb = 1'b0; vaddr = '0; fl = 1'b0; inv = 1'b0;
        itv = 1'b0; c2c = 1'b0;
        miss_fill = proc && !hit;
        way = hit ? hway : vway;
        wr_row = 1'b0;
        vline = ((32)'(r_tags[vway]) << SET_B) | 32'(r_set);
        if (proc) begin
            wr_row = 1'b1;
            if (hit) begin
                if (wr) begin
                    if (i_mode != MODE_WB) begin
                        if (olds == ST_S)
                            cmd = (i_mode == MODE_MSI) ? CMD_RDX : CMD_UPGR;
                        else if (olds == ST_O) cmd = CMD_UPGR;
                    end
                    news = ST_M;
                end
            end else begin
                if (r_sts[vway] == ST_M || r_sts[vway] == ST_O) begin
                    wb = 1'b1; vaddr = vline[25:0];
                end
                if (wr) begin
                    news = ST_M;
                    if (i_mode != MODE_WB) cmd = CMD_RDX;
                end else if (i_mode == MODE_WB || i_mode == MODE_MSI) begin
                    news = ST_S;
                    if (i_mode == MODE_MSI) cmd = CMD_RD;
                end else begin
                    news = r_sh ? ST_S : ST_E;
                    cmd = CMD_RD;
                end
                if (i_mode == MODE_MESI) c2c = r_sh;
                else if (i_mode == MODE_MOESI) c2c = r_dy;
            end
        end else if (hit && i_mode != MODE_WB && r_req <= REQ_BUPG) begin
            wr_row = 1'b1;
            case (r_req)
                REQ_BRD: begin
                    if (olds == ST_M) begin
                        news = (i_mode == MODE_MOESI) ? ST_O : ST_S;
                        fl = 1'b1; itv = 1'b1;
                    end else if (olds == ST_E) news = ST_S;
                    else if (olds == ST_O) fl = 1'b1;
                end
                REQ_BRDX: begin
                    news = ST_I; inv = 1'b1;
                    if (olds == ST_M || olds == ST_O ||
                        (olds == ST_E && i_mode == MODE_MESI)) fl = 1'b1;
                end
                default: begin
                    if (olds == ST_S || olds == ST_O) begin
                        news = ST_I; inv = 1'b1;
                    end
                end
            endcase
        end
        if (r_req > REQ_BUPG) begin
            olds = ST_I; news = ST_I; hit_out = 1'b0; wr_row = 1'b0;
        end
        n_sts = r_sts; n_sts[way] = news;
        n_tags = r_tags; if (miss_fill) n_tags[vway] = r_tag;
        n_rnks = r_rnks;
        trk = r_rnks[way];
        if (proc) begin
            for (int w = 0; w < WAYS; w++)
                if (r_rnks[w] > trk) n_rnks[w] = r_rnks[w] - RNK_W'(1);
            n_rnks[way] = RNK_W'(WAYS - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_tag  <= TAG_W'(i_address >> (OFF_W + SET_B));
            r_set  <= a_set;
            r_sh   <= i_shared_elsewhere;
            r_dy   <= i_dirty_elsewhere;
            r_tags <= r_tag_mem[a_set];
            r_sts  <= r_st_mem[a_set];
            r_rnks <= r_rk_mem[a_set];
        end
        if (i_cmd.clear) begin
            r_st_mem[r_clr] <= '0;
            r_rk_mem[r_clr] <= '0;
        end else if (i_cmd.update && wr_row) begin
            r_st_mem[r_set]  <= n_sts;
            r_rk_mem[r_set]  <= n_rnks;
            r_tag_mem[r_set] <= n_tags;
        end
        if (i_cmd.update) begin
            o_hit                 <= hit_out;
            o_bus_command         <= cmd;
            o_write_back          <= wb;
            o_victim_line_address <= vaddr;
            o_flush               <= fl;
            o_invalidation        <= inv;
            o_intervention        <= itv;
            o_cache_to_cache      <= c2c;
            o_old_state           <= olds;
            o_new_state           <= news;
        end
    end

    `include "coherent_set_assoc_cache_assert.svh"
    `CSC_ASSERT_IMP(a_wb_miss, i_clk, i_rst_n, i_cmd.update && wb, proc && !hit)
    `CSC_ASSERT_IMP(a_inv_new, i_clk, i_rst_n, i_cmd.update && inv, news == ST_I)
    `CSC_ASSERT_IMP(a_cmd_excl, i_clk, i_rst_n, i_cmd.update && i_cmd.clear, 1'b0)
endmodule
`default_nettype wire

FILE: rtl/coherent_set_assoc_cache.sv
// Top level of the coherent set-associative cache controller
//  channel | direction | handshake
//  in      | input     | i_valid / o_ready, fields i_req_type..i_dirty_elsewhere
//  out     | output    | o_valid / i_ready, fields o_hit..o_new_state
//  config  | input     | i_cfg_we / i_cfg_wdata, r_mode
// Each item reads one set row from the set memories, then does lookup,
// victim choice and row write back; no new item is taken before then.
// After reset a clearing pass zeroes the state and LRU rows of every set;
// no input is taken during it. A stalled result holds the next item back.
`default_nettype none
module coherent_set_assoc_cache #(
    parameter int SETS       = 256,
    parameter int WAYS       = 8,
    parameter int LINE_BYTES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [31:0] i_address,
    input  wire logic        i_shared_elsewhere,
    input  wire logic        i_dirty_elsewhere,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_hit,
    output logic [1:0]       o_bus_command,
    output logic             o_write_back,
    output logic [25:0]      o_victim_line_address,
    output logic             o_flush,
    output logic             o_invalidation,
    output logic             o_intervention,
    output logic             o_cache_to_cache,
    output logic [2:0]       o_old_state,
    output logic [2:0]       o_new_state
);
    import csac_pkg::*;

    logic [1:0]   r_mode;
    t_csac_cmd    cmd;
    t_csac_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= MODE_WB;
        else if (i_cfg_we) r_mode <= i_cfg_wdata;
    end

    csac_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_status(status), .o_cmd(cmd)
    );

    csac_dp #(.SETS(SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_mode(r_mode), .i_req_type(i_req_type), .i_address(i_address),
        .i_shared_elsewhere(i_shared_elsewhere),
        .i_dirty_elsewhere(i_dirty_elsewhere),
        .o_hit(o_hit), .o_bus_command(o_bus_command), .o_write_back(o_write_back),
        .o_victim_line_address(o_victim_line_address), .o_flush(o_flush),
        .o_invalidation(o_invalidation), .o_intervention(o_intervention),
        .o_cache_to_cache(o_cache_to_cache), .o_old_state(o_old_state),
        .o_new_state(o_new_state)
    );
endmodule
`default_nettype wire

FILE: tb/coherent_set_assoc_cache_tb.sv
// Testbench for the coherent set-associative cache controller
`default_nettype none
module coherent_set_assoc_cache_tb;
    import csac_pkg::*;

    localparam int NSETS = 256;
    localparam int NWAYS = 8;
    localparam int LBYTES = 64;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic        hit;
        logic [1:0]  bus_command;
        logic        write_back;
        logic [25:0] victim_line_address;
        logic        flush;
        logic        invalidation;
        logic        intervention;
        logic        cache_to_cache;
        logic [2:0]  old_state;
        logic [2:0]  new_state;
    } t_outcome;

    class cache_scoreboard;
        logic [17:0] tags[NSETS*NWAYS];
        logic [2:0]  states[NSETS*NWAYS];
        logic [2:0]  ranks[NSETS*NWAYS];
        logic [1:0]  mode;
        t_outcome    pending[$];
        int          errors;

        function void clear_state();
            foreach (tags[i]) begin
                tags[i] = '0;
                states[i] = ST_I;
                ranks[i] = '0;
            end
            mode = MODE_WB;
            errors = 0;
        endfunction

        function void promote(int base, int w);
            logic [2:0] r;
            r = ranks[base+w];
            for (int v = 0; v < NWAYS; v++)
                if (v != w && ranks[base+v] > r) ranks[base+v] = ranks[base+v] - 3'd1;
            ranks[base+w] = 3'(NWAYS - 1);
        endfunction

        function int pick_victim(int base);
            int best;
            int minr;
            best = 0;
            minr = 1 << 30;
            for (int v = 0; v < NWAYS; v++)
                if (states[base+v] == ST_I) return v;
            for (int v = 0; v < NWAYS; v++)
                if (ranks[base+v] <= minr) begin
                    minr = ranks[base+v];
                    best = v;
                end
            return best;
        endfunction

        function void note_request(logic [2:0] req, logic [31:0] addr, logic sh, logic dy);
            t_outcome o;
            logic [25:0] line;
            int set, base, way, v;
            logic [17:0] tag;
            o = '0;
            line = 26'(addr / LBYTES);
            set = line % NSETS;
            tag = 18'(line / NSETS);
            base = set * NWAYS;
            way = -1;
            o.old_state = ST_I;
            if (req <= REQ_BUPG) begin
                for (int w = 0; w < NWAYS; w++)
                    if (way < 0 && states[base+w] != ST_I && tags[base+w] == tag) way = w;
                if (way >= 0) begin
                    o.hit = 1'b1;
                    o.old_state = states[base+way];
                end
                o.new_state = o.old_state;
                if (req == REQ_RD || req == REQ_WR) begin
                    if (o.hit) begin
                        promote(base, way);
                        if (req == REQ_WR) begin
                            if (mode != MODE_WB) begin
                                if (o.old_state == ST_S)
                                    o.bus_command = (mode == MODE_MSI) ? CMD_RDX : CMD_UPGR;
                                else if (o.old_state == ST_O)
                                    o.bus_command = CMD_UPGR;
                            end
                            o.new_state = ST_M;
                        end
                    end else begin
                        v = pick_victim(base);
                        if (states[base+v] == ST_M || states[base+v] == ST_O) begin
                            o.write_back = 1'b1;
                            o.victim_line_address = 26'(tags[base+v] * NSETS + set);
                        end
                        promote(base, v);
                        tags[base+v] = tag;
                        way = v;
                        if (req == REQ_WR) begin
                            o.new_state = ST_M;
                            if (mode != MODE_WB) o.bus_command = CMD_RDX;
                        end else if (mode == MODE_WB || mode == MODE_MSI) begin
                            o.new_state = ST_S;
                            if (mode == MODE_MSI) o.bus_command = CMD_RD;
                        end else begin
                            o.new_state = sh ? ST_S : ST_E;
                            o.bus_command = CMD_RD;
                        end
                        if (mode == MODE_MESI) o.cache_to_cache = sh;
                        else if (mode == MODE_MOESI) o.cache_to_cache = dy;
                    end
                    states[base+way] = o.new_state;
                end else if (o.hit && mode != MODE_WB) begin
                    case (req)
                        REQ_BRD: begin
                            if (o.old_state == ST_M) begin
                                o.new_state = (mode == MODE_MOESI) ? ST_O : ST_S;
                                o.flush = 1'b1;
                                o.intervention = 1'b1;
                            end else if (o.old_state == ST_E) begin
                                o.new_state = ST_S;
                            end else if (o.old_state == ST_O) begin
                                o.flush = 1'b1;
                            end
                        end
                        REQ_BRDX: begin
                            o.new_state = ST_I;
                            o.invalidation = 1'b1;
                            if (o.old_state == ST_M || o.old_state == ST_O ||
                                (o.old_state == ST_E && mode == MODE_MESI))
                                o.flush = 1'b1;
                        end
                        default: begin
                            if (o.old_state == ST_S || o.old_state == ST_O) begin
                                o.new_state = ST_I;
                                o.invalidation = 1'b1;
                            end
                        end
                    endcase
                    states[base+way] = o.new_state;
                end
            end
            pending.push_back(o);
        endfunction

        function void check_result(t_outcome got);
            t_outcome e;
            if (pending.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.hit !== e.hit) begin
                $error("hit exp %0d got %0d", e.hit, got.hit); errors++;
            end
            if (got.bus_command !== e.bus_command) begin
                $error("bus_command exp %0d got %0d", e.bus_command, got.bus_command); errors++;
            end
            if (got.write_back !== e.write_back) begin
                $error("write_back exp %0d got %0d", e.write_back, got.write_back); errors++;
            end
            if (got.victim_line_address !== e.victim_line_address) begin
                $error("victim_line_address exp %0h got %0h",
                       e.victim_line_address, got.victim_line_address); errors++;
            end
            if (got.flush !== e.flush) begin
                $error("flush exp %0d got %0d", e.flush, got.flush); errors++;
            end
            if (got.invalidation !== e.invalidation) begin
                $error("invalidation exp %0d got %0d", e.invalidation, got.invalidation);
                errors++;
            end
            if (got.intervention !== e.intervention) begin
                $error("intervention exp %0d got %0d", e.intervention, got.intervention);
                errors++;
            end
            if (got.cache_to_cache !== e.cache_to_cache) begin
                $error("cache_to_cache exp %0d got %0d", e.cache_to_cache, got.cache_to_cache);
                errors++;
            end
            if (got.old_state !== e.old_state) begin
                $error("old_state exp %0d got %0d", e.old_state, got.old_state); errors++;
            end
            if (got.new_state !== e.new_state) begin
                $error("new_state exp %0d got %0d", e.new_state, got.new_state); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_req_type = '0;
    logic [31:0] i_address = '0;
    logic        i_shared_elsewhere = 1'b0;
    logic        i_dirty_elsewhere = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_outcome    res;

    int send_idle = 0;
    int recv_stall = 0;
    int idle_cycles = 0;
    bit timed_out = 0;
    cache_scoreboard sb;

    coherent_set_assoc_cache uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_address(i_address),
        .i_shared_elsewhere(i_shared_elsewhere), .i_dirty_elsewhere(i_dirty_elsewhere),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_hit(res.hit), .o_bus_command(res.bus_command), .o_write_back(res.write_back),
        .o_victim_line_address(res.victim_line_address), .o_flush(res.flush),
        .o_invalidation(res.invalidation), .o_intervention(res.intervention),
        .o_cache_to_cache(res.cache_to_cache), .o_old_state(res.old_state),
        .o_new_state(res.new_state)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: stall at the current percentage, check each transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_result(res);
            i_ready <= ($urandom_range(99) >= recv_stall);
            if ((o_valid && i_ready) || (i_valid && o_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("[coherent_set_assoc_cache] ERROR");
            $finish;
        end
    end

    // valid stays up between back-to-back transfers; drop it only when idling
    task automatic send_request(logic [2:0] req, logic [31:0] addr, logic sh, logic dy);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_address <= addr;
        i_shared_elsewhere <= sh;
        i_dirty_elsewhere <= dy;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(req, addr, sh, dy);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.mode = m;
    endtask

    // addresses drawn from a few tags in a few sets so lines collide and evict
    function automatic logic [31:0] pick_address();
        logic [31:0] a;
        a = $urandom;
        if ($urandom_range(9) != 0) begin
            a[13:6] = $urandom_range(3);
            a[31:14] = $urandom_range(11);
            if ($urandom_range(3) == 0) a[31:26] = 6'h3f;
        end
        return a;
    endfunction

    task automatic random_phase(int n, int s_idle, int r_stall);
        logic [2:0] req;
        send_idle = s_idle;
        recv_stall = r_stall;
        for (int k = 0; k < n; k++) begin
            req = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                             : 3'($urandom_range(REQ_BUPG));
            send_request(req, pick_address(), 1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        sb = new();
        sb.clear_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, unused codes, plain write-back mode
        send_request(REQ_RD, 32'h0, 1'b0, 1'b0);
        send_request(REQ_WR, 32'hffff_ffff, 1'b1, 1'b1);
        send_request(REQ_BRD, 32'hffff_ffff, 1'b0, 1'b0);
        send_request(3'd5, 32'h1234_5678, 1'b1, 1'b0);
        send_request(3'd7, 32'hffff_ffff, 1'b1, 1'b1);
        send_request(REQ_BRDX, 32'h0000_4000, 1'b0, 1'b0);
        set_mode(MODE_MOESI);
        send_request(REQ_RD, 32'h0000_0040, 1'b0, 1'b1);
        send_request(REQ_BRD, 32'h0000_0040, 1'b0, 1'b0);
        send_request(REQ_BRD, 32'hffff_ffff, 1'b0, 1'b0);
        send_request(REQ_BRD, 32'hffff_ffff, 1'b0, 1'b0);
        send_request(REQ_WR, 32'hffff_ffff, 1'b0, 1'b0);
        send_request(REQ_BUPG, 32'h0000_0040, 1'b0, 1'b0);
        // fill one set past its ways to force an LRU writeback
        for (int t = 0; t < 9; t++) send_request(REQ_WR, 32'(t) << 14, 1'b1, 1'b0);
        set_mode(MODE_MESI);
        send_request(REQ_RD, 32'h0000_0080, 1'b1, 1'b0);
        send_request(REQ_BRDX, 32'h0000_0080, 1'b0, 1'b0);

        random_phase(150, 0, 0);
        set_mode(MODE_MSI);
        random_phase(150, 48, 0);
        set_mode(MODE_MESI);
        random_phase(150, 0, 48);
        drain();
        set_mode(MODE_MOESI);
        random_phase(150, 25, 25);
        set_mode(MODE_WB);
        random_phase(100, 0, 0);
        set_mode(MODE_MESI);
        random_phase(100, 48, 48);
        set_mode(MODE_MOESI);
        random_phase(100, 0, 0);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[coherent_set_assoc_cache] OK");
        else
            $display("[coherent_set_assoc_cache] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
